/* src/fcb_pkg.sv */
// Shared types and constants for the clipping frame-store blitter.
// No dependencies; used by the top level, the pixel RAM and the port checker.
package fcb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int POS_W   = 11;
    localparam int SIZE_W  = 10;
    localparam int COLOR_W = 16;
    // signed width that holds a position plus a size without overflow
    localparam int CRD_W   = 13;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    // register word index, paddr[2]
    localparam logic REG_KEY = 1'b0;
    localparam logic [COLOR_W-1:0] KEY_RESET = 16'hF81F;

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = 2;
    localparam int RES_CW    = 3;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_FILL  = 2'd1,
        OP_IMAGE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_SETUP,
        ST_SWEEP,
        ST_RUN
    } state_t;

endpackage

/* src/fcb_ram.sv */
// Single-port synchronous pixel RAM with a registered read.
// Depends on fcb_pkg for the pixel width.
module fcb_ram #(
    parameter int DEPTH = 57600,
    parameter int AW    = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [fcb_pkg::COLOR_W-1:0] wdata,
    output logic [fcb_pkg::COLOR_W-1:0] rdata
);
    import fcb_pkg::*;

    logic [COLOR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* src/framebuffer_clip_blit.sv */
// RGB565 frame store with clear, clipped fill, color-keyed sprite pixels and reads.
// Depends on fcb_pkg and fcb_ram.
//
// Usage: items enter on in_valid/in_stall and are taken at an edge with valid
// high and stall low. Each item carries opcode, pos_x, pos_y, size_w, size_h,
// pixel_color. Only read items produce a result (read_value, read_valid) on
// out_valid/out_stall.
// Image pixels and reads can follow back to back; a read result passes the
// address register, the RAM read and the result queue before it reaches the
// output. Fill and clear sweep the clipped rectangle (the whole screen for a
// clear) after a setup state; a fill whose clipped area is empty is taken
// without a sweep. The single RAM port writes one pixel per cycle, and
// in_stall stays high for the setup and the sweep.
// A four-entry result queue sits ahead of the output; while the receiver
// stalls, items keep being taken until reads in flight plus queued results
// reach four, then in_stall rises.
// Reset: the store is swept to zero with in_stall high; register writes are
// taken throughout. The transparent key resets to 0xF81F and the sprite
// column and row counters to zero.
module framebuffer_clip_blit #(
    parameter int SCREEN_WIDTH  = fcb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fcb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcb_pkg::APB_AW-1:0]         paddr,
    input  logic [fcb_pkg::APB_DW-1:0]         pwdata,
    output logic [fcb_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic signed [fcb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [fcb_pkg::POS_W-1:0]   pos_y,
    input  logic [fcb_pkg::SIZE_W-1:0]         size_w,
    input  logic [fcb_pkg::SIZE_W-1:0]         size_h,
    input  logic [fcb_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fcb_pkg::COLOR_W-1:0]        read_value,
    output logic                               read_valid
);
    import fcb_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(SCREEN_WIDTH + 1);
    localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
    localparam logic signed [CRD_W-1:0] W_S = CRD_W'(SCREEN_WIDTH);
    localparam logic signed [CRD_W-1:0] H_S = CRD_W'(SCREEN_HEIGHT);

    // ---------------- configuration ----------------
    logic [COLOR_W-1:0] key_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEY) ? {{(APB_DW-COLOR_W){1'b0}}, key_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEY))
        begin
            key_reg <= pwdata[COLOR_W-1:0];
        end
    end

    // ---------------- control state ----------------
    state_t state_reg, state_next;

    logic              accept;
    logic              sweep_we;
    op_t               op;

    logic              s1_we_reg, s1_rd_reg, s1_on_reg;
    logic [CW-1:0]     s1_x_reg;
    logic [RW-1:0]     s1_y_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic              s2_rd_reg, s2_on_reg;

    logic [SIZE_W-1:0] img_col_reg, img_row_reg;

    logic [CW-1:0]     bx0_reg, bx1_reg, sw_col_reg;
    logic [RW-1:0]     by0_reg, by1_reg, sw_row_reg;
    logic [COLOR_W-1:0] fcolor_reg;
    logic [AW-1:0]     sw_addr_reg, sw_row_addr_reg;

    logic [COLOR_W-1:0] res_val [RES_DEPTH];
    logic               res_ok  [RES_DEPTH];
    logic [RES_AW-1:0]  res_wr_reg, res_rd_reg;
    logic [RES_CW-1:0]  res_cnt_reg;
    logic [RES_CW-1:0]  pend;

    assign op     = op_t'(opcode);
    assign accept = in_valid && !in_stall;
    assign pend   = res_cnt_reg + RES_CW'(s1_rd_reg) + RES_CW'(s2_rd_reg);

    // ---------------- item decode ----------------
    logic signed [CRD_W-1:0] xs, ys, ws, hs, fx0, fy0, fx1, fy1;
    logic                    fill_empty;
    logic                    img_skip, img_restart;
    logic [SIZE_W-1:0]       col_eff, row_eff, col_new, row_new;
    logic [SIZE_W:0]         col_inc, row_inc;
    logic signed [CRD_W-1:0] px, py;
    logic                    on_scr;

    always_comb
    begin
        xs = CRD_W'(pos_x);
        ys = CRD_W'(pos_y);
        ws = $signed({{(CRD_W-SIZE_W){1'b0}}, size_w});
        hs = $signed({{(CRD_W-SIZE_W){1'b0}}, size_h});

        fx0 = xs[CRD_W-1] ? '0 : xs;
        fy0 = ys[CRD_W-1] ? '0 : ys;
        fx1 = (xs + ws > W_S) ? W_S : xs + ws;
        fy1 = (ys + hs > H_S) ? H_S : ys + hs;
        fill_empty = (fx0 >= fx1) || (fy0 >= fy1);

        img_skip    = (size_w == '0) || (size_h == '0);
        img_restart = (img_col_reg >= size_w) || (img_row_reg >= size_h);
        col_eff = img_restart ? '0 : img_col_reg;
        row_eff = img_restart ? '0 : img_row_reg;
        col_inc = {1'b0, col_eff} + 1'b1;
        row_inc = {1'b0, row_eff} + 1'b1;
        if (img_skip)
        begin
            col_new = '0;
            row_new = '0;
        end
        else if (col_inc >= {1'b0, size_w})
        begin
            col_new = '0;
            row_new = (row_inc >= {1'b0, size_h}) ? '0 : row_inc[SIZE_W-1:0];
        end
        else
        begin
            col_new = col_inc[SIZE_W-1:0];
            row_new = row_eff;
        end

        if (op == OP_IMAGE)
        begin
            px = xs + $signed({{(CRD_W-SIZE_W){1'b0}}, col_eff});
            py = ys + $signed({{(CRD_W-SIZE_W){1'b0}}, row_eff});
        end
        else
        begin
            px = xs;
            py = ys;
        end
        on_scr = !px[CRD_W-1] && (px < W_S) && !py[CRD_W-1] && (py < H_S);
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SETUP:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if ((sw_col_reg + CW'(1)) == bx1_reg && (sw_row_reg + RW'(1)) == by1_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept && (op == OP_CLEAR || (op == OP_FILL && !fill_empty)))
                begin
                    state_next = ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_RUN) || (pend >= RES_CW'(RES_DEPTH));
        sweep_we = (state_reg == ST_SWEEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SETUP;
            img_col_reg <= '0;
            img_row_reg <= '0;
            s1_we_reg   <= 1'b0;
            s1_rd_reg   <= 1'b0;
            s2_rd_reg   <= 1'b0;
            bx0_reg     <= '0;
            bx1_reg     <= CW'(SCREEN_WIDTH);
            by0_reg     <= '0;
            by1_reg     <= RW'(SCREEN_HEIGHT);
            fcolor_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s1_we_reg <= accept && (op == OP_IMAGE) && !img_skip && on_scr
                         && (pixel_color != key_reg);
            s1_rd_reg <= accept && (op == OP_READ);
            s2_rd_reg <= s1_rd_reg;
            if (accept)
            begin
                unique case (op)
                    OP_CLEAR:
                    begin
                        bx0_reg    <= '0;
                        bx1_reg    <= CW'(SCREEN_WIDTH);
                        by0_reg    <= '0;
                        by1_reg    <= RW'(SCREEN_HEIGHT);
                        fcolor_reg <= pixel_color;
                    end
                    OP_FILL:
                    begin
                        bx0_reg    <= fx0[CW-1:0];
                        bx1_reg    <= fx1[CW-1:0];
                        by0_reg    <= fy0[RW-1:0];
                        by1_reg    <= fy1[RW-1:0];
                        fcolor_reg <= pixel_color;
                    end
                    OP_IMAGE:
                    begin
                        img_col_reg <= col_new;
                        img_row_reg <= row_new;
                    end
                    OP_READ:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // stage-1 payload and sweep walkers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_on_reg    <= on_scr;
            s1_x_reg     <= px[CW-1:0];
            s1_y_reg     <= py[RW-1:0];
            s1_color_reg <= pixel_color;
        end
        s2_on_reg <= s1_on_reg;

        if (state_reg == ST_SETUP)
        begin
            sw_addr_reg     <= AW'(int'(by0_reg) * SCREEN_WIDTH + int'(bx0_reg));
            sw_row_addr_reg <= AW'(int'(by0_reg) * SCREEN_WIDTH + int'(bx0_reg));
            sw_col_reg      <= bx0_reg;
            sw_row_reg      <= by0_reg;
        end
        else if (state_reg == ST_SWEEP)
        begin
            if ((sw_col_reg + CW'(1)) == bx1_reg)
            begin
                // next row of the rectangle
                sw_col_reg      <= bx0_reg;
                sw_row_reg      <= sw_row_reg + RW'(1);
                sw_row_addr_reg <= sw_row_addr_reg + AW'(SCREEN_WIDTH);
                sw_addr_reg     <= sw_row_addr_reg + AW'(SCREEN_WIDTH);
            end
            else
            begin
                sw_col_reg  <= sw_col_reg + CW'(1);
                sw_addr_reg <= sw_addr_reg + AW'(1);
            end
        end
    end

    // ---------------- pixel RAM ----------------
    logic               ram_en, ram_we;
    logic [AW-1:0]      ram_addr;
    logic [COLOR_W-1:0] ram_wdata, ram_q;

    always_comb
    begin
        ram_we = s1_we_reg || sweep_we;
        ram_en = ram_we || (s1_rd_reg && s1_on_reg);
        if (sweep_we)
        begin
            ram_addr  = sw_addr_reg;
            ram_wdata = fcolor_reg;
        end
        else
        begin
            ram_addr  = AW'(int'(s1_y_reg) * SCREEN_WIDTH + int'(s1_x_reg));
            ram_wdata = s1_color_reg;
        end
    end

    fcb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    // ---------------- result queue ----------------
    logic push, pop;

    assign push = s2_rd_reg;
    assign pop  = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_val[res_wr_reg] <= s2_on_reg ? ram_q : '0;
            res_ok[res_wr_reg]  <= s2_on_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                res_wr_reg <= res_wr_reg + RES_AW'(1);
            end
            if (pop)
            begin
                res_rd_reg <= res_rd_reg + RES_AW'(1);
            end
            res_cnt_reg <= res_cnt_reg + RES_CW'(push) - RES_CW'(pop);
        end
    end

    assign out_valid  = (res_cnt_reg != '0);
    assign read_value = res_val[res_rd_reg];
    assign read_valid = res_ok[res_rd_reg];

endmodule

/* src/fcb_checker.sv */
// Port-level checks for the frame-store blitter, bound to its top level.
// Depends on fcb_pkg and framebuffer_clip_blit.
module fcb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  opcode,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [fcb_pkg::COLOR_W-1:0] read_value,
    input logic                        read_valid
);
    import fcb_pkg::*;

    logic rd_taken, clr_taken;

    assign rd_taken  = in_valid && !in_stall && (opcode == OP_READ);
    assign clr_taken = in_valid && !in_stall && (opcode == OP_CLEAR);

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(read_valid))
        else $error("result changed while stalled");

    // off-screen reads report zero
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_value == '0)
        else $error("off-screen read with nonzero value");

    // a clear sweeps the store, so the next cycle cannot take an item
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clr_taken |=> in_stall)
        else $error("item taken right after a clear");

    // a rising out_valid traces to a read via address reg, RAM, queue
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rd_taken, 3))
        else $error("result without a matching read");

endmodule

bind framebuffer_clip_blit fcb_checker u_fcb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .read_valid (read_valid)
);

/* test/framebuffer_clip_blit_test.sv */
// Self-checking bench for framebuffer_clip_blit: clear, clipped fill, keyed sprite pixels, reads.
// Keeps its own copy of the frame store, sprite counters and key; checks every read result.
// Depends on fcb_pkg and the RTL of framebuffer_clip_blit.
module framebuffer_clip_blit_test;

    import fcb_pkg::*;

    localparam int SCR_W         = SCREEN_WIDTH_DEF;
    localparam int SCR_H         = SCREEN_HEIGHT_DEF;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 450;
    localparam int MAX_PRINTS    = 40;
    localparam logic [APB_AW-1:0] KEY_ADDR = {REG_KEY, 2'b00};

    typedef struct {
        op_t                        op;
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    y;
        logic [SIZE_W-1:0]          w;
        logic [SIZE_W-1:0]          h;
        logic [COLOR_W-1:0]         color;
    } blit_item_t;

    typedef struct {
        logic [COLOR_W-1:0] value;
        logic               hit;
    } pixel_answer_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 opcode = '0;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic [SIZE_W-1:0]          size_w = '0;
    logic [SIZE_W-1:0]          size_h = '0;
    logic [COLOR_W-1:0]         pixel_color = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [COLOR_W-1:0]         read_value;
    logic                       read_valid;

    // bench copy of the block state
    logic [COLOR_W-1:0]         frame_copy [SCR_W*SCR_H];
    int                         spr_col;
    int                         spr_row;
    logic [COLOR_W-1:0]         key_model;

    blit_item_t                 item_queue [$];
    pixel_answer_t              read_answers [$];

    logic                       in_taken = 1'b0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;
    logic                       hold_req = 1'b0;
    logic                       hold_off = 1'b0;
    int                         cycle_count = 0;
    int                         mismatches = 0;
    int                         n_items = 0;
    int                         n_checked = 0;
    int                         n_sprite_px = 0;
    int                         n_keyed = 0;
    int                         n_fills = 0;
    int                         n_clears = 0;
    int                         n_full_stalls = 0;

    framebuffer_clip_blit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .size_w      (size_w),
        .size_h      (size_h),
        .pixel_color (pixel_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .read_valid  (read_valid)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    // Applies one accepted item to the frame copy; reads queue their answer.
    function automatic void frame_apply(input blit_item_t it);
        int            xs;
        int            ys;
        int            wd;
        int            ht;
        int            xe;
        int            ye;
        int            px;
        int            py;
        pixel_answer_t ans;
        xs = int'(it.x);
        ys = int'(it.y);
        wd = int'(it.w);
        ht = int'(it.h);
        case (it.op)
            OP_CLEAR:
            begin
                foreach (frame_copy[i])
                    frame_copy[i] = it.color;
                n_clears++;
            end
            OP_FILL:
            begin
                xe = (xs + wd > SCR_W) ? SCR_W : xs + wd;
                ye = (ys + ht > SCR_H) ? SCR_H : ys + ht;
                for (py = (ys < 0 ? 0 : ys); py < ye; py++)
                    for (px = (xs < 0 ? 0 : xs); px < xe; px++)
                        frame_copy[py*SCR_W + px] = it.color;
                n_fills++;
            end
            OP_IMAGE:
            begin
                n_sprite_px++;
                if (wd == 0 || ht == 0)
                begin
                    spr_col = 0;
                    spr_row = 0;
                end
                else
                begin
                    // a size change mid-sprite restarts the raster walk
                    if (spr_col >= wd || spr_row >= ht)
                    begin
                        spr_col = 0;
                        spr_row = 0;
                    end
                    px = xs + spr_col;
                    py = ys + spr_row;
                    if (it.color == key_model)
                        n_keyed++;
                    else if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
                        frame_copy[py*SCR_W + px] = it.color;
                    spr_col++;
                    if (spr_col >= wd)
                    begin
                        spr_col = 0;
                        spr_row++;
                        if (spr_row >= ht)
                            spr_row = 0;
                    end
                end
            end
            OP_READ:
            begin
                if (xs >= 0 && xs < SCR_W && ys >= 0 && ys < SCR_H)
                begin
                    ans.value = frame_copy[ys*SCR_W + xs];
                    ans.hit   = 1'b1;
                end
                else
                begin
                    ans.value = '0;
                    ans.hit   = 1'b0;
                end
                read_answers.push_back(ans);
            end
        endcase
    endfunction

    // Input side: a new item goes out once the current one is taken.
    always @(negedge clk)
    begin : drive_items
        blit_item_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = item_queue.pop_front();
                in_valid    <= 1'b1;
                opcode      <= nxt.op;
                pos_x       <= nxt.x;
                pos_y       <= nxt.y;
                size_w      <= nxt.w;
                size_h      <= nxt.h;
                pixel_color <= nxt.color;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // long output hold-off so the result queue fills and the input backs up
    initial
    begin : receiver_hold
        while (!hold_req)
            @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : watch_ports
        blit_item_t    seen;
        pixel_answer_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            if (hold_off && in_valid && in_stall)
                n_full_stalls++;
            if (rst_n && in_valid && !in_stall)
            begin
                seen.op    = op_t'(opcode);
                seen.x     = pos_x;
                seen.y     = pos_y;
                seen.w     = size_w;
                seen.h     = size_h;
                seen.color = pixel_color;
                frame_apply(seen);
                in_taken = 1'b1;
            end
            if (rst_n && out_valid && !out_stall)
            begin
                if (read_answers.size() == 0)
                    report_mismatch($sformatf("result %h/%b with no read pending",
                                              read_value, read_valid));
                else
                begin
                    want = read_answers.pop_front();
                    if (read_value !== want.value)
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  read_value, want.value));
                    if (read_valid !== want.hit)
                        report_mismatch($sformatf("read_valid %b, want %b",
                                                  read_valid, want.hit));
                    n_checked++;
                end
            end
        end
    end

    task automatic write_key(input logic [COLOR_W-1:0] key);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= {16'($urandom), key};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        key_model = key;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_key(input logic [COLOR_W-1:0] key);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[COLOR_W-1:0] !== key)
            report_mismatch($sformatf("key reads %h, want %h", prdata[COLOR_W-1:0], key));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_item(input op_t op, input int x, input int y, input int w,
                             input int h, input logic [COLOR_W-1:0] c);
        blit_item_t it;
        it.op    = op;
        it.x     = POS_W'(x);
        it.y     = POS_W'(y);
        it.w     = SIZE_W'(w);
        it.h     = SIZE_W'(h);
        it.color = c;
        item_queue.push_back(it);
        n_items++;
    endtask

    // Mostly whole sprites with random colors, reads aimed at fresh pixels,
    // small fills, some broken sprites and raw noise, rare clears.
    task automatic queue_random(input int target);
        int                 made;
        int                 pick;
        int                 sx;
        int                 sy;
        int                 sw;
        int                 sh;
        int                 cut;
        int                 k;
        logic [COLOR_W-1:0] c;
        made = 0;
        while (made < target)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                sw  = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
                sh  = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
                sx  = $urandom_range(0, 263) - 12;
                sy  = $urandom_range(0, 263) - 12;
                cut = ($urandom_range(7) == 0) ? $urandom_range(0, sw*sh - 1) : sw*sh;
                for (k = 0; k < cut; k++)
                begin
                    c = ($urandom_range(5) == 0) ? key_model : COLOR_W'($urandom);
                    push_item(OP_IMAGE, sx, sy, sw, sh, c);
                    made++;
                    if ($urandom_range(5) == 0)
                    begin
                        push_item(OP_READ, sx + $urandom_range(0, sw - 1),
                                  sy + $urandom_range(0, sh - 1), 0, 0, '0);
                        made++;
                    end
                end
                if (cut == sw*sh)
                begin
                    push_item(OP_READ, sx + $urandom_range(0, sw - 1),
                              sy + $urandom_range(0, sh - 1), 0, 0, '0);
                    push_item(OP_READ, sx + $urandom_range(0, sw - 1),
                              sy + $urandom_range(0, sh - 1), 0, 0, '0);
                    made += 2;
                end
            end
            else if (pick < 72)
            begin
                if ($urandom_range(3) == 0)
                    push_item(OP_READ, $urandom, $urandom, $urandom, $urandom,
                              COLOR_W'($urandom));
                else
                    push_item(OP_READ, $urandom_range(0, SCR_W + 1) - 1,
                              $urandom_range(0, SCR_H + 1) - 1, 0, 0, '0);
                made++;
            end
            else if (pick < 84)
            begin
                if ($urandom_range(19) == 0)
                begin
                    sx = int'($signed(POS_W'($urandom)));
                    sy = int'($signed(POS_W'($urandom)));
                    sw = $urandom_range(0, 1023);
                    sh = $urandom_range(0, 1023);
                end
                else
                begin
                    sx = $urandom_range(0, 271) - 16;
                    sy = $urandom_range(0, 271) - 16;
                    sw = $urandom_range(0, 31);
                    sh = $urandom_range(0, 31);
                end
                push_item(OP_FILL, sx, sy, sw, sh, COLOR_W'($urandom));
                push_item(OP_READ, sx + $urandom_range(0, sw), sy + $urandom_range(0, sh),
                          0, 0, '0);
                made += 2;
            end
            else if (pick == 99 && $urandom_range(3) == 0)
            begin
                push_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                          COLOR_W'($urandom));
                made++;
            end
            else
            begin
                // raw image item: any origin, any size, breaks the running sprite
                push_item(OP_IMAGE, $urandom, $urandom, $urandom, $urandom,
                          COLOR_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (item_queue.size() != 0 || in_valid || read_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        // a clear or a large fill may still be sweeping
        while (in_stall)
            @(negedge clk);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct,
                             input logic [COLOR_W-1:0] key, input logic pressure);
        write_key(key);
        check_key(key);
        send_idle_pct <= s_pct;
        recv_idle_pct <= r_pct;
        @(posedge clk);
        queue_random(PHASE_ITEMS);
        if (pressure)
            hold_req <= 1'b1;
        wait_idle();
    endtask

    initial
    begin : stimulus
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        spr_col   = 0;
        spr_row   = 0;
        key_model = KEY_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_key(KEY_RESET);

        @(posedge clk);
        push_item(OP_READ, 0, 0, 0, 0, '0);
        push_item(OP_READ, -1, 0, 0, 0, '0);
        push_item(OP_READ, SCR_W, SCR_H - 1, 0, 0, '0);
        push_item(OP_CLEAR, 0, 0, 0, 0, 16'hFFFF);
        push_item(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, '0);
        // rectangle wholly left of and above the screen
        push_item(OP_FILL, -1024, -1024, 1023, 1023, 16'h1234);
        push_item(OP_FILL, SCR_W - 10, SCR_H - 5, 1023, 1023, 16'h0000);
        push_item(OP_FILL, 10, 10, 0, 50, 16'h0000);
        push_item(OP_FILL, -5, -5, 8, 8, 16'hABCD);
        // 2x2 sprite in the bottom right corner, one pixel in the key color
        push_item(OP_IMAGE, SCR_W - 2, SCR_H - 2, 2, 2, 16'h0001);
        push_item(OP_IMAGE, SCR_W - 2, SCR_H - 2, 2, 2, KEY_RESET);
        push_item(OP_IMAGE, SCR_W - 2, SCR_H - 2, 2, 2, 16'h0003);
        push_item(OP_IMAGE, SCR_W - 2, SCR_H - 2, 2, 2, 16'h0004);
        push_item(OP_IMAGE, 20, 20, 0, 3, 16'h5555);
        // size shrinks mid-sprite: counters restart
        push_item(OP_IMAGE, 100, 100, 3, 2, 16'h7777);
        push_item(OP_IMAGE, 50, 50, 1, 1, 16'h8888);
        push_item(OP_IMAGE, 1023, 1023, 1023, 1023, 16'h9999);
        push_item(OP_READ, SCR_W - 2, SCR_H - 2, 0, 0, '0);
        push_item(OP_READ, SCR_W - 1, SCR_H - 2, 0, 0, '0);
        push_item(OP_READ, SCR_W - 2, SCR_H - 1, 0, 0, '0);
        push_item(OP_READ, SCR_W - 1, SCR_H - 1, 0, 0, '0);
        push_item(OP_READ, 50, 50, 0, 0, '0);
        push_item(OP_READ, 0, 0, 0, 0, '0);
        push_item(OP_READ, 1023, -1024, 1023, 1023, 16'hFFFF);
        wait_idle();

        run_phase(29, 69, 16'h0000, 1'b0);
        run_phase(69, 29, 16'hFFFF, 1'b0);
        run_phase(0, 0, COLOR_W'($urandom), 1'b1);

        $display("%0d items: %0d reads checked, %0d sprite pixels (%0d keyed out), %0d fills, %0d clears",
                 n_items, n_checked, n_sprite_px, n_keyed, n_fills, n_clears);
        $display("four key values; input held off %0d cycles while the output was blocked",
                 n_full_stalls);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
